// ----- hw/rtl/btt_pkg.sv -----
// ----------------------------------------------------------------------------
// btt_pkg
// Shared types and codes of the brace template tokeniser: byte classes,
// queue entry format, result kinds and error codes.
// ----------------------------------------------------------------------------
package btt_pkg;

  // Depth of the queue between front and back; must be a power of two
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Significant characters
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;
  localparam logic [7:0] CH_UNDER = 8'h5F;

  // Result kinds
  localparam logic [2:0] KIND_PENDING = 3'd0;
  localparam logic [2:0] KIND_LIT     = 3'd1;
  localparam logic [2:0] KIND_NAME    = 3'd2;
  localparam logic [2:0] KIND_CLOSED  = 3'd3;
  localparam logic [2:0] KIND_SKIP    = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_STRAY    = 3'd1;
  localparam logic [2:0] ERR_DANGLING = 3'd2;
  localparam logic [2:0] ERR_EMPTY    = 3'd3;
  localparam logic [2:0] ERR_START    = 3'd4;
  localparam logic [2:0] ERR_INNER    = 3'd5;

  // Byte class worked out by the front end
  typedef enum logic [2:0] {
    CLS_OPEN,
    CLS_CLOSE,
    CLS_ALPHA,   // letter or underscore: may start a name
    CLS_DIGIT,
    CLS_OTHER
  } cls_t;

  // One classified word in the queue
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    cls_t       cls;
  } entry_t;

  // Queue status seen by the back end
  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

// ----- hw/rtl/brace_template_tokenizer.sv -----
// ----------------------------------------------------------------------------
// brace_template_tokenizer
// Classifies template bytes as literal text, escaped braces, variable-name
// bytes or block closes, and reports the first syntax error of a pattern.
// ----------------------------------------------------------------------------
//  channel  | handshake        | words
//  ---------+------------------+-------------------------------------------
//  input    | push / full      | byte_in, last
//  result   | empty / pop      | out_byte, kind, name_first, error_code
//
//  One word in, one word out; sustained rate one byte per cycle while the
//  result side pops, limited by the mode update in the back end.
//  A pushed byte passes the queue, then the output register, before its
//  result shows.
//  rst (synchronous) empties the queue and output and returns to text mode.
//  A stalled result side fills the four-word queue before full rises.
// ----------------------------------------------------------------------------
module brace_template_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] byte_in,
  input  logic       last,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic [2:0] kind,
  output logic       name_first,
  output logic [2:0] error_code
);

  btt_pkg::fifo_stat_t stat;
  btt_pkg::entry_t     wr_data;
  btt_pkg::entry_t     rd_data;
  logic                wr_en;
  logic                rd_en;

  btt_front u_front (
    .push    (push),
    .full    (full),
    .byte_in (byte_in),
    .last    (last),
    .stat    (stat),
    .wr_en   (wr_en),
    .wr_data (wr_data)
  );

  btt_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (wr_en),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_data (rd_data),
    .stat    (stat)
  );

  btt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .rd_data    (rd_data),
    .stat       (stat),
    .rd_en      (rd_en),
    .empty      (empty),
    .pop        (pop),
    .out_byte   (out_byte),
    .kind       (kind),
    .name_first (name_first),
    .error_code (error_code)
  );

endmodule

// ----- hw/rtl/btt_front.sv -----
// ----------------------------------------------------------------------------
// btt_front
// Input side: takes pattern bytes and tags each with its character class
// before it enters the queue.
// ----------------------------------------------------------------------------
module btt_front (
  input  logic              push,
  output logic              full,
  input  logic [7:0]        byte_in,
  input  logic              last,
  input  btt_pkg::fifo_stat_t stat,
  output logic              wr_en,
  output btt_pkg::entry_t   wr_data
);

  // Character class of the incoming byte
  btt_pkg::cls_t cls;

  always_comb begin
    if (byte_in == btt_pkg::CH_OPEN) begin
      cls = btt_pkg::CLS_OPEN;
    end else if (byte_in == btt_pkg::CH_CLOSE) begin
      cls = btt_pkg::CLS_CLOSE;
    end else if ((byte_in >= 8'h41 && byte_in <= 8'h5A) ||
                 (byte_in >= 8'h61 && byte_in <= 8'h7A) ||
                 byte_in == btt_pkg::CH_UNDER) begin
      cls = btt_pkg::CLS_ALPHA;
    end else if (byte_in >= 8'h30 && byte_in <= 8'h39) begin
      cls = btt_pkg::CLS_DIGIT;
    end else begin
      cls = btt_pkg::CLS_OTHER;
    end
  end

  // Queue write
  assign full         = stat.full;
  assign wr_en        = push && !stat.full;
  assign wr_data.data = byte_in;
  assign wr_data.last = last;
  assign wr_data.cls  = cls;

endmodule

// ----- hw/rtl/btt_fifo.sv -----
// ----------------------------------------------------------------------------
// btt_fifo
// Short queue of classified words between front and back ends.
// ----------------------------------------------------------------------------
module btt_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  btt_pkg::entry_t     wr_data,
  input  logic                rd_en,
  output btt_pkg::entry_t     rd_data,
  output btt_pkg::fifo_stat_t stat
);

  btt_pkg::entry_t              mem [btt_pkg::FIFO_DEPTH];
  logic [btt_pkg::FIFO_AW-1:0]  wr_ptr;
  logic [btt_pkg::FIFO_AW-1:0]  rd_ptr;
  logic [btt_pkg::FIFO_AW:0]    count;

  // Storage; entries need no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + 1'b1;
      if (rd_en) rd_ptr <= rd_ptr + 1'b1;
      unique case ({wr_en, rd_en})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign rd_data    = mem[rd_ptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == (btt_pkg::FIFO_AW+1)'(btt_pkg::FIFO_DEPTH));

endmodule

// ----- hw/rtl/btt_back.sv -----
// ----------------------------------------------------------------------------
// btt_back
// Parser state machine: walks the classified words, tracks the brace mode
// and holds the result word in an output register.
// ----------------------------------------------------------------------------
module btt_back (
  input  logic                clk,
  input  logic                rst,
  input  btt_pkg::entry_t     rd_data,
  input  btt_pkg::fifo_stat_t stat,
  output logic                rd_en,
  output logic                empty,
  input  logic                pop,
  output logic [7:0]          out_byte,
  output logic [2:0]          kind,
  output logic                name_first,
  output logic [2:0]          error_code
);

  typedef enum logic [2:0] {
    MODE_TEXT,
    MODE_OPEN,
    MODE_CLOSE,
    MODE_NAME,
    MODE_ERR
  } mode_t;

  mode_t      mode, mode_next;
  logic       out_valid;
  logic [7:0] ob_next;
  logic [2:0] kind_next;
  logic       first_next;
  logic [2:0] err_next;

  // Take a word when the output register is free or being drained
  assign rd_en = !stat.empty && (!out_valid || pop);
  assign empty = !out_valid;

  // Next mode and result for the word at the queue head
  always_comb begin
    ob_next    = rd_data.data;
    kind_next  = btt_pkg::KIND_LIT;
    first_next = 1'b0;
    err_next   = btt_pkg::ERR_NONE;
    mode_next  = MODE_TEXT;
    unique case (mode)
      MODE_TEXT: begin
        if (rd_data.cls == btt_pkg::CLS_OPEN) begin
          kind_next = btt_pkg::KIND_PENDING;
          mode_next = MODE_OPEN;
          if (rd_data.last) err_next = btt_pkg::ERR_DANGLING;
        end else if (rd_data.cls == btt_pkg::CLS_CLOSE) begin
          kind_next = btt_pkg::KIND_PENDING;
          mode_next = MODE_CLOSE;
          if (rd_data.last) err_next = btt_pkg::ERR_STRAY;
        end
      end
      MODE_OPEN: begin
        if (rd_data.cls == btt_pkg::CLS_OPEN) begin
          kind_next = btt_pkg::KIND_LIT;
        end else if (rd_data.cls == btt_pkg::CLS_CLOSE) begin
          err_next = btt_pkg::ERR_EMPTY;
        end else if (rd_data.cls == btt_pkg::CLS_ALPHA) begin
          kind_next  = btt_pkg::KIND_NAME;
          first_next = 1'b1;
          mode_next  = MODE_NAME;
          if (rd_data.last) err_next = btt_pkg::ERR_DANGLING;
        end else begin
          err_next = btt_pkg::ERR_START;
        end
      end
      MODE_CLOSE: begin
        if (rd_data.cls != btt_pkg::CLS_CLOSE) err_next = btt_pkg::ERR_STRAY;
      end
      MODE_NAME: begin
        if (rd_data.cls == btt_pkg::CLS_CLOSE) begin
          kind_next = btt_pkg::KIND_CLOSED;
        end else if (rd_data.cls == btt_pkg::CLS_ALPHA ||
                     rd_data.cls == btt_pkg::CLS_DIGIT) begin
          kind_next = btt_pkg::KIND_NAME;
          mode_next = MODE_NAME;
          if (rd_data.last) err_next = btt_pkg::ERR_DANGLING;
        end else begin
          err_next = btt_pkg::ERR_INNER;
        end
      end
      default: begin
        // error skip, and any unused mode code
        kind_next = btt_pkg::KIND_SKIP;
        ob_next   = 8'h00;
        mode_next = MODE_ERR;
      end
    endcase

    // An error blanks the word and enters skip
    if (err_next != btt_pkg::ERR_NONE) begin
      kind_next  = btt_pkg::KIND_SKIP;
      ob_next    = 8'h00;
      first_next = 1'b0;
      mode_next  = MODE_ERR;
    end
    // End of pattern always returns to text
    if (rd_data.last) mode_next = MODE_TEXT;
  end

  // Mode and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_TEXT;
      out_valid <= 1'b0;
    end else begin
      if (rd_en) begin
        mode      <= mode_next;
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
    if (rd_en) begin
      out_byte   <= ob_next;
      kind       <= kind_next;
      name_first <= first_next;
      error_code <= err_next;
    end
  end

endmodule

// ----- hw/rtl/btt_checker.sv -----
// ----------------------------------------------------------------------------
// btt_checker
// Port-level checks on the result words of the tokeniser.
// ----------------------------------------------------------------------------
module btt_checker (
  input logic       clk,
  input logic       rst,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte,
  input logic [2:0] kind,
  input logic       name_first,
  input logic [2:0] error_code
);

  // A reported error always comes as a blank skip word
  a_err_is_skip: assert property (@(posedge clk) disable iff (rst)
    (!empty && error_code != btt_pkg::ERR_NONE) |->
      (kind == btt_pkg::KIND_SKIP && out_byte == 8'h00 && !name_first))
    else $error("error word not blanked");

  // Skip words carry no byte
  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == btt_pkg::KIND_SKIP) |-> (out_byte == 8'h00))
    else $error("skip word with data");

  // First-of-name flag only on name bytes
  a_first_name: assert property (@(posedge clk) disable iff (rst)
    (!empty && name_first) |-> (kind == btt_pkg::KIND_NAME))
    else $error("name_first on non-name word");

  // Pending words are braces
  a_pending_brace: assert property (@(posedge clk) disable iff (rst)
    (!empty && kind == btt_pkg::KIND_PENDING) |->
      (out_byte == btt_pkg::CH_OPEN || out_byte == btt_pkg::CH_CLOSE))
    else $error("pending word is not a brace");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(kind)))
    else $error("stalled result changed");

endmodule

bind brace_template_tokenizer btt_checker u_btt_checker (
  .clk        (clk),
  .rst        (rst),
  .empty      (empty),
  .pop        (pop),
  .out_byte   (out_byte),
  .kind       (kind),
  .name_first (name_first),
  .error_code (error_code)
);
